FILE: hdl/bcs_pkg.sv
`timescale 1ns / 1ps

package bcs_pkg;

    localparam int MAX_PERIOD = 64;
    localparam int CNT_W      = $clog2(MAX_PERIOD);
    localparam int PRICE_W    = 32;
    localparam int PER_W      = 7;
    localparam int SUM_W      = PRICE_W + CNT_W;
    localparam int AVG_W      = PRICE_W + 16;
    localparam int ALPHA_W    = 17;

    localparam logic [PER_W-1:0] IDX_MAX    = 7'd127;
    localparam logic [PER_W-1:0] STREAK_MAX = 7'd127;

    // Rule numbers.
    localparam logic [4:0] RULE_ALWAYS    = 5'd0;
    localparam logic [4:0] RULE_ABOVE     = 5'd1;
    localparam logic [4:0] RULE_BELOW     = 5'd2;
    localparam logic [4:0] RULE_SMA_X_UP  = 5'd3;
    localparam logic [4:0] RULE_SMA_X_DN  = 5'd4;
    localparam logic [4:0] RULE_HIGH_BRK  = 5'd5;
    localparam logic [4:0] RULE_LOW_BRK   = 5'd6;
    localparam logic [4:0] RULE_CROSS_UP  = 5'd7;
    localparam logic [4:0] RULE_CROSS_DN  = 5'd8;
    localparam logic [4:0] RULE_OVER_AVG  = 5'd9;
    localparam logic [4:0] RULE_UNDER_AVG = 5'd10;
    localparam logic [4:0] RULE_SLOPE_UP  = 5'd11;
    localparam logic [4:0] RULE_SLOPE_DN  = 5'd12;
    localparam logic [4:0] RULE_BULL      = 5'd13;
    localparam logic [4:0] RULE_BEAR      = 5'd14;
    localparam logic [4:0] RULE_VOL_HI    = 5'd15;
    localparam logic [4:0] RULE_VOL_LO    = 5'd16;
    localparam logic [4:0] RULE_STREAK_UP = 5'd17;
    localparam logic [4:0] RULE_STREAK_DN = 5'd18;
    localparam logic [4:0] RULE_CHG_UP    = 5'd19;
    localparam logic [4:0] RULE_CHG_DN    = 5'd20;
    localparam logic [4:0] RULE_INSIDE    = 5'd21;
    localparam logic [4:0] RULE_GAP_UP    = 5'd22;
    localparam logic [4:0] RULE_GAP_DN    = 5'd23;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KIND   = 3'd0;
    localparam logic [2:0] CFG_AVG    = 3'd1;
    localparam logic [2:0] CFG_P1     = 3'd2;
    localparam logic [2:0] CFG_P2     = 3'd3;
    localparam logic [2:0] CFG_P3     = 3'd4;
    localparam logic [2:0] CFG_THR    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_CMP
    } t_state;

    typedef struct packed {
        logic [PRICE_W-1:0] close;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] volume;
        logic [AVG_W-1:0]   hist;
    } t_bar_rec;

    typedef struct packed {
        logic rotate;
        logic push;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic go;
        logic clear;
        logic first;
    } t_ema_ctl;

    typedef struct packed {
        logic [4:0]          kind;
        logic                ema;
        logic signed [31:0]  thr;
        logic [PER_W-1:0]    p0;
        logic [PER_W-1:0]    p1;
        logic [PER_W-1:0]    p2;
        logic [PER_W-1:0]    bars;
        logic [PER_W-1:0]    streak;
        logic [PRICE_W-1:0]  o;
        logic [PRICE_W-1:0]  h;
        logic [PRICE_W-1:0]  l;
        logic [PRICE_W-1:0]  c;
        logic [PRICE_W-1:0]  v;
        logic [PRICE_W-1:0]  c0;
        logic [PRICE_W-1:0]  h0;
        logic [PRICE_W-1:0]  l0;
        logic [PRICE_W-1:0]  maxh;
        logic [PRICE_W-1:0]  minl;
        logic [SUM_W-1:0]    sn0;
        logic [SUM_W-1:0]    sn1;
        logic [SUM_W-1:0]    sn2;
        logic [SUM_W-1:0]    sp0;
        logic [SUM_W-1:0]    sp1;
        logic [SUM_W-1:0]    vsn;
        logic [AVG_W-1:0]    e0;
        logic [AVG_W-1:0]    e1;
        logic [AVG_W-1:0]    e2;
        logic [AVG_W-1:0]    ep0;
        logic [AVG_W-1:0]    past;
    } t_judge_in;

    function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] p);
        logic [PER_W-1:0] r;
        if (p == '0) begin
            r = PER_W'(1);
        end else if (p > PER_W'(MAX_PERIOD)) begin
            r = PER_W'(MAX_PERIOD);
        end else begin
            r = p;
        end
        return r;
    endfunction

    // round(2^17 / (p + 1)) in Q16.
    function automatic logic [ALPHA_W-1:0] alpha_q16(input logic [PER_W-1:0] p);
        logic [ALPHA_W-1:0] a;
        case (p)
            7'd1:  a = 17'd65536;  7'd2:  a = 17'd43691;  7'd3:  a = 17'd32768;
            7'd4:  a = 17'd26214;  7'd5:  a = 17'd21845;  7'd6:  a = 17'd18725;
            7'd7:  a = 17'd16384;  7'd8:  a = 17'd14564;  7'd9:  a = 17'd13107;
            7'd10: a = 17'd11916;  7'd11: a = 17'd10923;  7'd12: a = 17'd10082;
            7'd13: a = 17'd9362;   7'd14: a = 17'd8738;   7'd15: a = 17'd8192;
            7'd16: a = 17'd7710;   7'd17: a = 17'd7282;   7'd18: a = 17'd6899;
            7'd19: a = 17'd6554;   7'd20: a = 17'd6242;   7'd21: a = 17'd5958;
            7'd22: a = 17'd5699;   7'd23: a = 17'd5461;   7'd24: a = 17'd5243;
            7'd25: a = 17'd5041;   7'd26: a = 17'd4855;   7'd27: a = 17'd4681;
            7'd28: a = 17'd4520;   7'd29: a = 17'd4369;   7'd30: a = 17'd4228;
            7'd31: a = 17'd4096;   7'd32: a = 17'd3972;   7'd33: a = 17'd3855;
            7'd34: a = 17'd3745;   7'd35: a = 17'd3641;   7'd36: a = 17'd3542;
            7'd37: a = 17'd3449;   7'd38: a = 17'd3361;   7'd39: a = 17'd3277;
            7'd40: a = 17'd3197;   7'd41: a = 17'd3121;   7'd42: a = 17'd3048;
            7'd43: a = 17'd2979;   7'd44: a = 17'd2913;   7'd45: a = 17'd2849;
            7'd46: a = 17'd2789;   7'd47: a = 17'd2731;   7'd48: a = 17'd2675;
            7'd49: a = 17'd2621;   7'd50: a = 17'd2570;   7'd51: a = 17'd2521;
            7'd52: a = 17'd2473;   7'd53: a = 17'd2427;   7'd54: a = 17'd2383;
            7'd55: a = 17'd2341;   7'd56: a = 17'd2300;   7'd57: a = 17'd2260;
            7'd58: a = 17'd2222;   7'd59: a = 17'd2185;   7'd60: a = 17'd2149;
            7'd61: a = 17'd2114;   7'd62: a = 17'd2081;   7'd63: a = 17'd2048;
            7'd64: a = 17'd2016;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: hdl/bcs_cell.sv
`timescale 1ns / 1ps

module bcs_cell
    import bcs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_bar_rec  i_from_prev,
    input  t_bar_rec  i_from_next,
    output t_bar_rec  o_rec
);

    t_bar_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= '0;
        end else if (i_ctl.rotate) begin
            r_rec <= i_from_next;
        end else if (i_ctl.push) begin
            r_rec <= i_ctl.clear ? '0 : i_from_prev;
        end
    end

    assign o_rec = r_rec;

endmodule

FILE: hdl/bcs_ema.sv
`timescale 1ns / 1ps

module bcs_ema
    import bcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ema_ctl           i_ctl,
    input  logic [PRICE_W-1:0] i_close,
    input  logic [PER_W-1:0]   i_period [3],
    output logic [AVG_W-1:0]   o_avg [3],
    output logic [AVG_W-1:0]   o_prev [3]
);

    localparam logic [1:0] PH_DIFF = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_ADD  = 2'd2;

    logic [AVG_W-1:0]   r_avg [3];
    logic [AVG_W-1:0]   r_prev [3];
    logic               r_busy;
    logic [1:0]         r_k;
    logic [1:0]         r_ph;
    logic               r_up;
    logic [AVG_W-1:0]   r_diff;
    logic [48:0]        r_hi;
    logic [ALPHA_W-1:0] r_lo;

    logic [AVG_W-1:0]   w_x;
    logic [AVG_W-1:0]   w_old;
    logic [ALPHA_W-1:0] w_alpha;
    logic [48:0]        w_hi;
    logic [32:0]        w_lo_full;
    logic [48:0]        w_step;
    logic [AVG_W-1:0]   w_new;

    assign w_x       = {i_close, 16'h0000};
    assign w_old     = i_ctl.clear ? '0 : r_avg[r_k];
    assign w_alpha   = alpha_q16(i_period[r_k]);
    assign w_hi      = r_diff[AVG_W-1:16] * w_alpha;
    assign w_lo_full = r_diff[15:0] * w_alpha;
    assign w_step    = r_hi + 49'(r_lo);

    always_comb begin
        if (i_ctl.first) begin
            w_new = w_x;
        end else if (r_up) begin
            w_new = w_old + w_step[AVG_W-1:0];
        end else begin
            w_new = w_old - w_step[AVG_W-1:0];
        end
    end

    // One shared step unit walks the three averages: difference, scale, update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_ph   <= PH_DIFF;
            r_avg  <= '{default: '0};
            r_prev <= '{default: '0};
        end else if (i_ctl.go) begin
            r_busy <= 1'b1;
            r_k    <= '0;
            r_ph   <= PH_DIFF;
        end else if (r_busy) begin
            case (r_ph)
                PH_DIFF: begin
                    r_up   <= w_x >= w_old;
                    r_diff <= (w_x >= w_old) ? w_x - w_old : w_old - w_x;
                    r_ph   <= PH_MUL;
                end
                PH_MUL: begin
                    r_hi <= w_hi;
                    r_lo <= w_lo_full[32:16];
                    r_ph <= PH_ADD;
                end
                PH_ADD: begin
                    r_avg[r_k]  <= w_new;
                    r_prev[r_k] <= w_old;
                    r_ph        <= PH_DIFF;
                    if (r_k == 2'd2) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                default: r_ph <= PH_DIFF;
            endcase
        end
    end

    assign o_avg  = r_avg;
    assign o_prev = r_prev;

endmodule

FILE: hdl/bcs_judge.sv
`timescale 1ns / 1ps

module bcs_judge
    import bcs_pkg::*;
(
    input  logic      i_clk,
    input  t_judge_in i_in,
    input  logic      i_mul,
    output logic      o_hit
);

    logic [AVG_W-1:0]   w_ax, w_ay, w_bx, w_by;
    logic [PER_W-1:0]   w_anx, w_any, w_bnx, w_bny;
    logic [AVG_W-1:0]   w_mv0, w_mv1, w_mv2, w_pv0, w_cmv, w_cpv;
    logic [PER_W-1:0]   w_mn0, w_mn1, w_mn2;
    logic [PRICE_W-1:0] w_lv;
    logic [14:0]        w_lm;
    logic [SUM_W-1:0]   w_sa;
    logic signed [33:0] w_f;

    logic [54:0]        r_ax, r_ay, r_bx, r_by;
    logic [46:0]        r_lhs;
    logic [63:0]        r_plo;
    logic [37:0]        r_phi;
    logic               r_fle0, r_fnz, r_anz;

    logic [69:0]        w_prod;
    logic               w_a_gt, w_a_lt, w_b_gt, w_b_lt, w_s_gt, w_s_lt;
    logic [PER_W-1:0]   w_mx01, w_mx3;
    logic [PER_W:0]     w_b1;
    logic               w_vn, w_vp, w_slope_ok, w_align_ok, w_one;

    always_comb begin
        w_mv0 = i_in.ema ? i_in.e0 : AVG_W'(i_in.sn0);
        w_mv1 = i_in.ema ? i_in.e1 : AVG_W'(i_in.sn1);
        w_mv2 = i_in.ema ? i_in.e2 : AVG_W'(i_in.sn2);
        w_pv0 = i_in.ema ? i_in.ep0 : AVG_W'(i_in.sp0);
        w_mn0 = i_in.ema ? PER_W'(1) : i_in.p0;
        w_mn1 = i_in.ema ? PER_W'(1) : i_in.p1;
        w_mn2 = i_in.ema ? PER_W'(1) : i_in.p2;
        w_cmv = i_in.ema ? {i_in.c, 16'h0000} : AVG_W'(i_in.c);
        w_cpv = i_in.ema ? {i_in.c0, 16'h0000} : AVG_W'(i_in.c0);

        w_ax = '0; w_anx = PER_W'(1); w_ay = '0; w_any = PER_W'(1);
        w_bx = '0; w_bnx = PER_W'(1); w_by = '0; w_bny = PER_W'(1);
        w_lv = '0; w_lm = '0; w_sa = '0; w_f = '0;

        case (i_in.kind)
            RULE_SMA_X_UP, RULE_SMA_X_DN: begin
                w_ax = AVG_W'(i_in.sp0); w_anx = i_in.p1;
                w_ay = AVG_W'(i_in.sp1); w_any = i_in.p0;
                w_bx = AVG_W'(i_in.sn0); w_bnx = i_in.p1;
                w_by = AVG_W'(i_in.sn1); w_bny = i_in.p0;
            end
            RULE_HIGH_BRK: begin
                w_ax = AVG_W'(i_in.c); w_ay = AVG_W'(i_in.maxh);
            end
            RULE_LOW_BRK: begin
                w_ax = AVG_W'(i_in.c); w_ay = AVG_W'(i_in.minl);
            end
            RULE_CROSS_UP, RULE_CROSS_DN, RULE_OVER_AVG, RULE_UNDER_AVG: begin
                w_ax = w_cpv; w_anx = w_mn0; w_ay = w_pv0;
                w_bx = w_cmv; w_bnx = w_mn0; w_by = w_mv0;
            end
            RULE_SLOPE_UP, RULE_SLOPE_DN: begin
                w_ax = w_mv0; w_ay = i_in.past;
            end
            RULE_BULL, RULE_BEAR: begin
                w_ax = w_mv0; w_anx = w_mn1; w_ay = w_mv1; w_any = w_mn0;
                w_bx = w_mv1; w_bnx = w_mn2; w_by = w_mv2; w_bny = w_mn1;
            end
            RULE_VOL_HI, RULE_VOL_LO: begin
                w_lv = i_in.v; w_lm = {i_in.p0, 8'h00};
                w_sa = i_in.vsn; w_f = 34'(i_in.thr);
            end
            RULE_CHG_UP, RULE_CHG_DN: begin
                w_lv = i_in.c; w_lm = 15'd10000;
                w_sa = SUM_W'(i_in.c0); w_f = 34'sd10000 + 34'(i_in.thr);
            end
            RULE_GAP_UP: begin
                w_lv = i_in.o; w_lm = 15'd10000;
                w_sa = SUM_W'(i_in.h0); w_f = 34'sd10000 + 34'(i_in.thr);
            end
            RULE_GAP_DN: begin
                w_lv = i_in.o; w_lm = 15'd10000;
                w_sa = SUM_W'(i_in.l0); w_f = 34'sd10000 - 34'(i_in.thr);
            end
            default: begin
                w_ax = '0;
            end
        endcase
    end

    // Cross-multiplied operands and the scaled-threshold product parts.
    always_ff @(posedge i_clk) begin
        if (i_mul) begin
            r_ax   <= w_ax * w_anx;
            r_ay   <= w_ay * w_any;
            r_bx   <= w_bx * w_bnx;
            r_by   <= w_by * w_bny;
            r_lhs  <= w_lv * w_lm;
            r_plo  <= w_sa[31:0] * w_f[31:0];
            r_phi  <= w_sa[SUM_W-1:32] * w_f[31:0];
            r_fle0 <= w_f <= 34'sd0;
            r_fnz  <= w_f != 34'sd0;
            r_anz  <= w_sa != '0;
        end
    end

    assign w_prod = {r_phi, 32'h0} + 70'(r_plo);
    assign w_a_gt = r_ax > r_ay;
    assign w_a_lt = r_ax < r_ay;
    assign w_b_gt = r_bx > r_by;
    assign w_b_lt = r_bx < r_by;

    // A threshold at or below zero only leaves "above" or "equal".
    assign w_s_gt = r_fle0 ? ((r_lhs != '0) || (r_anz && r_fnz)) : (70'(r_lhs) > w_prod);
    assign w_s_lt = r_fle0 ? 1'b0 : (70'(r_lhs) < w_prod);

    assign w_mx01     = (i_in.p0 > i_in.p1) ? i_in.p0 : i_in.p1;
    assign w_mx3      = (w_mx01 > i_in.p2) ? w_mx01 : i_in.p2;
    assign w_b1       = {1'b0, i_in.bars} + 8'd1;
    assign w_one      = i_in.bars != '0;
    assign w_vn       = i_in.ema || (w_b1 >= {1'b0, i_in.p0});
    assign w_vp       = w_one && (i_in.ema || (i_in.bars >= i_in.p0));
    assign w_slope_ok = (i_in.bars >= i_in.p1)
                        && (i_in.ema || (w_b1 >= ({1'b0, i_in.p1} + {1'b0, i_in.p0})));
    assign w_align_ok = i_in.ema || (w_b1 >= {1'b0, w_mx3});

    always_comb begin
        case (i_in.kind)
            RULE_ALWAYS:    o_hit = 1'b1;
            RULE_ABOVE:     o_hit = i_in.thr[31] || (i_in.c > i_in.thr[31:0]);
            RULE_BELOW:     o_hit = !i_in.thr[31] && (i_in.thr != 32'sd0)
                                    && (i_in.c < i_in.thr[31:0]);
            RULE_SMA_X_UP:  o_hit = (i_in.bars >= w_mx01) && !w_a_gt && w_b_gt;
            RULE_SMA_X_DN:  o_hit = (i_in.bars >= w_mx01) && !w_a_lt && w_b_lt;
            RULE_HIGH_BRK:  o_hit = (i_in.bars >= i_in.p0) && w_a_gt;
            RULE_LOW_BRK:   o_hit = (i_in.bars >= i_in.p0) && w_a_lt;
            RULE_CROSS_UP:  o_hit = w_vn && w_vp && !w_a_gt && w_b_gt;
            RULE_CROSS_DN:  o_hit = w_vn && w_vp && !w_a_lt && w_b_lt;
            RULE_OVER_AVG:  o_hit = w_vn && w_b_gt;
            RULE_UNDER_AVG: o_hit = w_vn && w_b_lt;
            RULE_SLOPE_UP:  o_hit = w_slope_ok && w_a_gt;
            RULE_SLOPE_DN:  o_hit = w_slope_ok && w_a_lt;
            RULE_BULL:      o_hit = w_align_ok && w_a_gt && w_b_gt;
            RULE_BEAR:      o_hit = w_align_ok && w_a_lt && w_b_lt;
            RULE_VOL_HI:    o_hit = (i_in.bars >= i_in.p0) && (i_in.vsn != '0) && w_s_gt;
            RULE_VOL_LO:    o_hit = (i_in.bars >= i_in.p0) && (i_in.vsn != '0) && w_s_lt;
            RULE_STREAK_UP, RULE_STREAK_DN: o_hit = i_in.streak >= i_in.p0;
            RULE_CHG_UP:    o_hit = w_one && (i_in.c0 != '0) && !w_s_lt;
            RULE_CHG_DN:    o_hit = w_one && (i_in.c0 != '0) && !w_s_gt;
            RULE_INSIDE:    o_hit = w_one && (i_in.h <= i_in.h0) && (i_in.l >= i_in.l0);
            RULE_GAP_UP:    o_hit = w_one && (i_in.h0 != '0) && w_s_gt;
            RULE_GAP_DN:    o_hit = w_one && (i_in.l0 != '0) && w_s_lt;
            default:        o_hit = 1'b0;
        endcase
    end

endmodule

FILE: hdl/bar_condition_signal_top.sv
`timescale 1ns / 1ps

// Evaluates one trading rule per price bar and returns one flag per bar. The last
// 64 bars (close, high, low, volume and the first-period average) sit in a row of
// 64 cells. For each item the row rotates once through its head cell while the
// window sums, the breakout extremes and the lookback value build up and one shared
// step unit updates the three exponential averages; the PREP, MUL and CMP states then
// form the sums, the cross products and the flag, CMP holding while the output is
// full. A new item is accepted only in the idle state, so items do not overlap.
// Configuration may be written at any idle time and takes effect on the next item.

module bar_condition_signal_top
    import bcs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [159:0] i_s_tdata,   // open, high, low, close, volume price fields
    input  logic         i_s_tuser,   // series_start
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [7:0]   o_m_tdata,   // signal_hit, then zero fill
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic [4:0]         r_kind;
    logic               r_ema;
    logic [PER_W-1:0]   r_p1, r_p2, r_p3;
    logic signed [31:0] r_thr;

    logic [PRICE_W-1:0] r_o, r_h, r_l, r_c, r_v;
    logic               r_start;
    logic [PER_W-1:0]   r_bar, r_streak;
    logic [CNT_W-1:0]   r_cnt;

    logic [SUM_W-1:0]   r_sp [3];
    logic [PRICE_W-1:0] r_tap [3];
    logic [SUM_W-1:0]   r_sn [3];
    logic [SUM_W-1:0]   r_vsp, r_vsn;
    logic [PRICE_W-1:0] r_vtap;
    logic [PRICE_W-1:0] r_maxh, r_minl, r_c0, r_h0, r_l0;
    logic [AVG_W-1:0]   r_past;

    logic               r_ovalid, r_ohit;

    logic [PER_W-1:0]   w_p [3];
    logic [PER_W-1:0]   w_b;
    logic               w_accept, w_out_free, w_done, w_hit, w_match;
    logic [PER_W-1:0]   w_streak_old, w_streak_new;
    logic [PER_W-1:0]   w_i;
    t_bar_rec           w_head, w_new;
    t_bar_rec           w_rec [MAX_PERIOD];
    t_cell_ctl          w_cell_ctl;
    t_ema_ctl           w_ema_ctl;
    t_judge_in          w_jin;
    logic [AVG_W-1:0]   w_avg [3];
    logic [AVG_W-1:0]   w_avg_prev [3];

    assign w_p[0] = eff_period(r_p1);
    assign w_p[1] = eff_period(r_p2);
    assign w_p[2] = eff_period(r_p3);
    assign w_b    = r_start ? '0 : r_bar;

    assign o_s_tready  = r_state == ST_IDLE;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_ovalid || i_m_tready;
    assign w_done      = (r_state == ST_CMP) && w_out_free;
    assign w_i         = {1'b0, r_cnt};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= RULE_ALWAYS;
            r_ema  <= 1'b0;
            r_p1   <= 7'd20;
            r_p2   <= 7'd20;
            r_p3   <= 7'd60;
            r_thr  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KIND: r_kind <= i_cfg_data[4:0];
                CFG_AVG:  r_ema  <= i_cfg_data[0];
                CFG_P1:   r_p1   <= i_cfg_data[PER_W-1:0];
                CFG_P2:   r_p2   <= i_cfg_data[PER_W-1:0];
                CFG_P3:   r_p3   <= i_cfg_data[PER_W-1:0];
                CFG_THR:  r_thr  <= i_cfg_data;
                default:  r_kind <= r_kind;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_SCAN;
            ST_SCAN: if (r_cnt == '1) n_state = ST_PREP;
            ST_PREP: n_state = ST_MUL;
            ST_MUL:  n_state = ST_CMP;
            ST_CMP:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Item registers and the scan accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_accept) begin
            r_cnt <= '0;
        end else if (r_state == ST_SCAN) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_o     <= i_s_tdata[31:0];
            r_h     <= i_s_tdata[63:32];
            r_l     <= i_s_tdata[95:64];
            r_c     <= i_s_tdata[127:96];
            r_v     <= i_s_tdata[159:128];
            r_start <= i_s_tuser;
            r_sp    <= '{default: '0};
            r_vsp   <= '0;
        end else if (r_state == ST_SCAN) begin
            for (int k = 0; k < 3; k++) begin
                if (w_i < w_p[k]) begin
                    r_sp[k] <= r_sp[k] + SUM_W'(w_head.close);
                end
                if (w_i == w_p[k] - 7'd1) begin
                    r_tap[k] <= w_head.close;
                end
            end
            if (w_i < w_p[0]) begin
                r_vsp <= r_vsp + SUM_W'(w_head.volume);
                if (r_cnt == '0 || w_head.high > r_maxh) r_maxh <= w_head.high;
                if (r_cnt == '0 || w_head.low < r_minl)  r_minl <= w_head.low;
            end
            if (w_i == w_p[0] - 7'd1) r_vtap <= w_head.volume;
            if (w_i == w_p[1] - 7'd1) r_past <= w_head.hist;
            if (r_cnt == '0) begin
                r_c0 <= w_head.close;
                r_h0 <= w_head.high;
                r_l0 <= w_head.low;
            end
        end else if (r_state == ST_PREP) begin
            // Window including this bar: previous window minus its oldest entry.
            for (int k = 0; k < 3; k++) begin
                r_sn[k] <= SUM_W'(r_c) + r_sp[k] - SUM_W'(r_tap[k]);
            end
            r_vsn <= SUM_W'(r_v) + r_vsp - SUM_W'(r_vtap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar    <= '0;
            r_streak <= '0;
        end else if (w_done) begin
            r_bar    <= (w_b < IDX_MAX) ? w_b + 7'd1 : IDX_MAX;
            r_streak <= w_streak_new;
        end
    end

    assign w_match      = (r_kind == RULE_STREAK_DN) ? (r_c < r_o) : (r_c > r_o);
    assign w_streak_old = r_start ? '0 : r_streak;
    assign w_streak_new = w_match ? ((w_streak_old < STREAK_MAX) ? w_streak_old + 7'd1
                                                                 : STREAK_MAX) : '0;

    // Cell row: rotates toward the head while scanning, shifts in the new bar at the end.
    assign w_head = r_start ? '0 : w_rec[0];

    always_comb begin
        w_new.close  = r_c;
        w_new.high   = r_h;
        w_new.low    = r_l;
        w_new.volume = r_v;
        w_new.hist   = r_ema ? w_avg[0] : AVG_W'(r_sn[0]);
    end

    assign w_cell_ctl.rotate = r_state == ST_SCAN;
    assign w_cell_ctl.push   = w_done;
    assign w_cell_ctl.clear  = r_start;

    for (genvar g = 0; g < MAX_PERIOD; g++) begin : g_cell
        t_cell_ctl w_ctl;
        t_bar_rec  w_prev;

        assign w_ctl.rotate = w_cell_ctl.rotate;
        assign w_ctl.push   = w_cell_ctl.push;
        if (g == 0) begin : g_head
            assign w_prev      = w_new;
            assign w_ctl.clear = 1'b0;
        end else begin : g_body
            assign w_prev      = w_rec[g-1];
            assign w_ctl.clear = w_cell_ctl.clear;
        end

        bcs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_from_prev (w_prev),
            .i_from_next (w_rec[(g + 1) % MAX_PERIOD]),
            .o_rec       (w_rec[g])
        );
    end

    assign w_ema_ctl.go    = (r_state == ST_SCAN) && (r_cnt == '0);
    assign w_ema_ctl.clear = r_start;
    assign w_ema_ctl.first = w_b == '0;

    bcs_ema u_ema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ema_ctl),
        .i_close  (r_c),
        .i_period (w_p),
        .o_avg    (w_avg),
        .o_prev   (w_avg_prev)
    );

    always_comb begin
        w_jin.kind   = r_kind;
        w_jin.ema    = r_ema;
        w_jin.thr    = r_thr;
        w_jin.p0     = w_p[0];
        w_jin.p1     = w_p[1];
        w_jin.p2     = w_p[2];
        w_jin.bars   = w_b;
        w_jin.streak = w_streak_new;
        w_jin.o      = r_o;
        w_jin.h      = r_h;
        w_jin.l      = r_l;
        w_jin.c      = r_c;
        w_jin.v      = r_v;
        w_jin.c0     = r_c0;
        w_jin.h0     = r_h0;
        w_jin.l0     = r_l0;
        w_jin.maxh   = r_maxh;
        w_jin.minl   = r_minl;
        w_jin.sn0    = r_sn[0];
        w_jin.sn1    = r_sn[1];
        w_jin.sn2    = r_sn[2];
        w_jin.sp0    = r_sp[0];
        w_jin.sp1    = r_sp[1];
        w_jin.vsn    = r_vsn;
        w_jin.e0     = w_avg[0];
        w_jin.e1     = w_avg[1];
        w_jin.e2     = w_avg[2];
        w_jin.ep0    = w_avg_prev[0];
        w_jin.past   = r_past;
    end

    bcs_judge u_judge (
        .i_clk (i_clk),
        .i_in  (w_jin),
        .i_mul (r_state == ST_MUL),
        .o_hit (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_ohit <= w_hit;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'b0, r_ohit};

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_SCAN)
        else $error("accepted item did not start a scan");

    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_cnt == '1) |=> r_state == ST_PREP)
        else $error("scan did not end after the last cell");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_CMP))
        else $error("result appeared without an evaluation");

    a_bar_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> r_bar != '0)
        else $error("bar count not advanced after an item");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bcs_pkg::*;

    localparam int WATCH_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 80;

    typedef longint unsigned t_u64;
    typedef t_u64 t_line [64];

    typedef struct {
        logic [31:0] o;
        logic [31:0] h;
        logic [31:0] l;
        logic [31:0] c;
        logic [31:0] v;
        bit          start;
    } t_bar;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    bar_condition_signal_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the rule settings and the bar history.
    logic [4:0]  rule_sel;
    bit          ema_sel;
    logic [6:0]  per_raw [3];
    longint      thr_val;
    t_line       close_ln, high_ln, low_ln, vol_ln, avg_hist;
    t_u64        ema_now [3];
    t_u64        ema_prev [3];
    t_u64        bar_cnt, streak_cnt;

    bit          hit_q [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          burst_mode = 1'b0;
    int          stall_left = 0;
    longint      walk_px = 1000;
    longint      walk_bias = 0;

    function automatic void clear_series();
        for (int i = 0; i < 64; i++) begin
            close_ln[i] = 0; high_ln[i] = 0; low_ln[i] = 0; vol_ln[i] = 0; avg_hist[i] = 0;
        end
        for (int k = 0; k < 3; k++) begin
            ema_now[k] = 0; ema_prev[k] = 0;
        end
        bar_cnt = 0;
        streak_cnt = 0;
    endfunction

    function automatic t_u64 clamp_per(logic [6:0] p);
        if (p == 0) return 1;
        if (p > 64) return 64;
        return t_u64'(p);
    endfunction

    function automatic t_u64 alpha_of(t_u64 p);
        return (131072 + (p + 1) / 2) / (p + 1);
    endfunction

    function automatic t_u64 scale_q16(t_u64 d, t_u64 a);
        return (d >> 16) * a + (((d & 64'hFFFF) * a) >> 16);
    endfunction

    function automatic t_u64 sum_incl(t_line ln, t_u64 cur, t_u64 p);
        t_u64 s;
        s = cur;
        for (int i = 0; i + 1 < p; i++) s += ln[i];
        return s;
    endfunction

    function automatic t_u64 sum_back(t_line ln, t_u64 p);
        t_u64 s;
        s = 0;
        for (int i = 0; i < p; i++) s += ln[i];
        return s;
    endfunction

    function automatic int cmp_ratio(t_u64 av, t_u64 an, t_u64 bv, t_u64 bn);
        t_u64 x, y;
        x = av * bn;
        y = bv * an;
        return x > y ? 1 : (x < y ? -1 : 0);
    endfunction

    // Sign of lhs - a * f, without wrapping the product.
    function automatic int cmp_scaled(t_u64 lhs, t_u64 a, longint f);
        t_u64 r;
        if (f <= 0) begin
            if (lhs > 0) return 1;
            return (a == 0 || f == 0) ? 0 : 1;
        end
        if (a != 0 && t_u64'(f) > (64'hFFFF_FFFF_FFFF_FFFF / a)) return -1;
        r = a * t_u64'(f);
        return lhs > r ? 1 : (lhs < r ? -1 : 0);
    endfunction

    function automatic bit eval_bar(t_bar br);
        t_u64 o, h, l, c, v, b, x, e, a, cur_first, mx, lev, vs, look, past;
        t_u64 p [3];
        t_u64 nv [3];
        t_u64 nn [3];
        t_u64 pv [3];
        t_u64 pn [3];
        t_u64 cmv, cpmv, sn0, sn1, sp0, sp1;
        bit   ema, match, vn, vp, hit;
        int   r;
        o = br.o; h = br.h; l = br.l; c = br.c; v = br.v;
        if (br.start) clear_series();
        b = bar_cnt;
        ema = ema_sel;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) p[k] = clamp_per(per_raw[k]);
        for (int k = 0; k < 3; k++) begin
            x = c << 16;
            e = ema_now[k];
            a = alpha_of(p[k]);
            ema_prev[k] = e;
            if (b == 0) e = x;
            else if (x >= e) e += scale_q16(x - e, a);
            else e -= scale_q16(e - x, a);
            ema_now[k] = e;
        end
        for (int k = 0; k < 3; k++) begin
            if (ema) begin
                nv[k] = ema_now[k]; nn[k] = 1; pv[k] = ema_prev[k]; pn[k] = 1;
            end else begin
                nv[k] = sum_incl(close_ln, c, p[k]); nn[k] = p[k];
                pv[k] = sum_back(close_ln, p[k]); pn[k] = p[k];
            end
        end
        cmv = ema ? (c << 16) : c;
        cpmv = ema ? (close_ln[0] << 16) : close_ln[0];
        cur_first = nv[0];

        match = (rule_sel == RULE_STREAK_DN) ? (c < o) : (c > o);
        streak_cnt = match ? (streak_cnt < 127 ? streak_cnt + 1 : 127) : 0;

        case (rule_sel)
            RULE_ALWAYS: hit = 1'b1;
            RULE_ABOVE:  hit = longint'(c) > thr_val;
            RULE_BELOW:  hit = thr_val > 0 && longint'(c) < thr_val;
            RULE_SMA_X_UP, RULE_SMA_X_DN: begin
                mx = p[0] > p[1] ? p[0] : p[1];
                sn0 = sum_incl(close_ln, c, p[0]);
                sn1 = sum_incl(close_ln, c, p[1]);
                sp0 = sum_back(close_ln, p[0]);
                sp1 = sum_back(close_ln, p[1]);
                if (b >= mx) begin
                    if (rule_sel == RULE_SMA_X_UP)
                        hit = cmp_ratio(sp0, p[0], sp1, p[1]) <= 0
                              && cmp_ratio(sn0, p[0], sn1, p[1]) > 0;
                    else
                        hit = cmp_ratio(sp0, p[0], sp1, p[1]) >= 0
                              && cmp_ratio(sn0, p[0], sn1, p[1]) < 0;
                end
            end
            RULE_HIGH_BRK, RULE_LOW_BRK: begin
                if (b >= p[0]) begin
                    lev = (rule_sel == RULE_HIGH_BRK) ? high_ln[0] : low_ln[0];
                    for (int i = 1; i < p[0]; i++) begin
                        if (rule_sel == RULE_HIGH_BRK && high_ln[i] > lev) lev = high_ln[i];
                        if (rule_sel == RULE_LOW_BRK && low_ln[i] < lev) lev = low_ln[i];
                    end
                    hit = (rule_sel == RULE_HIGH_BRK) ? c > lev : c < lev;
                end
            end
            RULE_CROSS_UP, RULE_CROSS_DN, RULE_OVER_AVG, RULE_UNDER_AVG: begin
                vn = ema || b + 1 >= p[0];
                vp = b >= 1 && (ema || b >= p[0]);
                if (vn) begin
                    if (rule_sel == RULE_OVER_AVG) hit = cmp_ratio(cmv, 1, nv[0], nn[0]) > 0;
                    else if (rule_sel == RULE_UNDER_AVG)
                        hit = cmp_ratio(cmv, 1, nv[0], nn[0]) < 0;
                    else if (vp) begin
                        if (rule_sel == RULE_CROSS_UP)
                            hit = cmp_ratio(cpmv, 1, pv[0], pn[0]) <= 0
                                  && cmp_ratio(cmv, 1, nv[0], nn[0]) > 0;
                        else
                            hit = cmp_ratio(cpmv, 1, pv[0], pn[0]) >= 0
                                  && cmp_ratio(cmv, 1, nv[0], nn[0]) < 0;
                    end
                end
            end
            RULE_SLOPE_UP, RULE_SLOPE_DN: begin
                look = p[1];
                past = avg_hist[look - 1];
                if (b >= look && (ema || b + 1 >= look + p[0]))
                    hit = (rule_sel == RULE_SLOPE_UP) ? cur_first > past : cur_first < past;
            end
            RULE_BULL, RULE_BEAR: begin
                mx = p[0];
                if (p[1] > mx) mx = p[1];
                if (p[2] > mx) mx = p[2];
                if (ema || b + 1 >= mx) begin
                    if (rule_sel == RULE_BULL)
                        hit = cmp_ratio(nv[0], nn[0], nv[1], nn[1]) > 0
                              && cmp_ratio(nv[1], nn[1], nv[2], nn[2]) > 0;
                    else
                        hit = cmp_ratio(nv[0], nn[0], nv[1], nn[1]) < 0
                              && cmp_ratio(nv[1], nn[1], nv[2], nn[2]) < 0;
                end
            end
            RULE_VOL_HI, RULE_VOL_LO: begin
                vs = sum_incl(vol_ln, v, p[0]);
                if (b >= p[0] && vs > 0) begin
                    r = cmp_scaled(v * p[0] * 256, vs, thr_val);
                    hit = (rule_sel == RULE_VOL_HI) ? r > 0 : r < 0;
                end
            end
            RULE_STREAK_UP, RULE_STREAK_DN: hit = streak_cnt >= p[0];
            RULE_CHG_UP, RULE_CHG_DN: begin
                if (b >= 1 && close_ln[0] != 0) begin
                    r = cmp_scaled(c * 10000, close_ln[0], 10000 + thr_val);
                    hit = (rule_sel == RULE_CHG_UP) ? r >= 0 : r <= 0;
                end
            end
            RULE_INSIDE: if (b >= 1) hit = h <= high_ln[0] && l >= low_ln[0];
            RULE_GAP_UP:
                if (b >= 1 && high_ln[0] != 0)
                    hit = cmp_scaled(o * 10000, high_ln[0], 10000 + thr_val) > 0;
            RULE_GAP_DN:
                if (b >= 1 && low_ln[0] != 0)
                    hit = cmp_scaled(o * 10000, low_ln[0], 10000 - thr_val) < 0;
            default: hit = 1'b0;
        endcase

        for (int i = 63; i > 0; i--) begin
            avg_hist[i] = avg_hist[i-1];
            close_ln[i] = close_ln[i-1];
            high_ln[i] = high_ln[i-1];
            low_ln[i] = low_ln[i-1];
            vol_ln[i] = vol_ln[i-1];
        end
        avg_hist[0] = cur_first;
        close_ln[0] = c;
        high_ln[0] = h;
        low_ln[0] = l;
        vol_ln[0] = v;
        if (bar_cnt < 127) bar_cnt++;
        return hit;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] clip32(longint x);
        if (x < 0) return 32'd0;
        if (x > 64'sh0FFFF_FFFF) return 32'hFFFF_FFFF;
        return x[31:0];
    endfunction

    function automatic t_bar make_bar(logic [31:0] o, logic [31:0] h, logic [31:0] l,
                                      logic [31:0] c, logic [31:0] v, bit start);
        t_bar br;
        br.o = o; br.h = h; br.l = l; br.c = c; br.v = v; br.start = start;
        return br;
    endfunction

    // Random-walk bar, with occasional gaps, near-zero prices and full-range noise.
    function automatic t_bar walk_bar(bit start);
        t_bar   br;
        longint o, c, hi, lo;
        int     r;
        r = $urandom_range(0, 99);
        br.start = start;
        if (r < 4) begin
            br.o = $urandom; br.h = $urandom; br.l = $urandom; br.c = $urandom;
            br.v = $urandom;
            return br;
        end
        if (r < 6) walk_px = $urandom_range(0, 3);
        o = walk_px;
        if (r >= 6 && r < 12) o = walk_px + walk_px / 40 + 1;
        else if (r >= 12 && r < 18) o = walk_px - walk_px / 40 - 1;
        c = o + longint'($urandom_range(0, 400)) - 200 + walk_bias;
        hi = (o > c ? o : c) + longint'($urandom_range(0, 120));
        lo = (o < c ? o : c) - longint'($urandom_range(0, 120));
        br.o = clip32(o);
        br.c = clip32(c);
        br.h = clip32(hi);
        br.l = clip32(lo);
        walk_px = br.c;
        r = $urandom_range(0, 99);
        if (r < 5) br.v = 0;
        else if (r < 10) br.v = $urandom;
        else br.v = $urandom_range(1000, 3000);
        return br;
    endfunction

    task automatic send_bar(t_bar br);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata <= {br.v, br.c, br.l, br.h, br.o};
        s_tuser <= br.start;
        s_tvalid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (s_tready) break;
        end
        hit_q = {hit_q, eval_bar(br)};
    endtask

    task automatic end_items();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (cfg_ready) break;
        end
        case (idx)
            CFG_KIND: rule_sel = data[4:0];
            CFG_AVG:  ema_sel = data[0];
            CFG_P1:   per_raw[0] = data[6:0];
            CFG_P2:   per_raw[1] = data[6:0];
            CFG_P3:   per_raw[2] = data[6:0];
            CFG_THR:  thr_val = longint'(signed'(data));
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes every register; the bits above each field carry random junk.
    task automatic setup_rule(logic [4:0] kind, bit avg, logic [6:0] pa, logic [6:0] pb,
                              logic [6:0] pc, logic [31:0] thr);
        wait_drained();
        write_reg(CFG_KIND, 32'({$urandom, kind}));
        write_reg(CFG_AVG, 32'({$urandom, avg}));
        write_reg(CFG_P1, 32'({$urandom, pa}));
        write_reg(CFG_P2, 32'({$urandom, pb}));
        write_reg(CFG_P3, 32'({$urandom, pc}));
        write_reg(CFG_THR, thr);
    endtask

    function automatic logic [6:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 7'd0;
        if (r < 18) return 7'd64;
        if (r < 23) return 7'($urandom_range(65, 127));
        return 7'($urandom_range(1, 8));
    endfunction

    function automatic logic [31:0] pick_threshold(logic [4:0] kind);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'h8000_0000;
        if (r < 10) return 32'h7FFF_FFFF;
        if (r < 15) return $urandom;
        case (kind)
            RULE_ABOVE, RULE_BELOW: return clip32(walk_px + $urandom_range(0, 400) - 200);
            RULE_VOL_HI, RULE_VOL_LO: return 32'(int'($urandom_range(0, 640)) - 64);
            RULE_CHG_UP, RULE_CHG_DN, RULE_INSIDE, RULE_GAP_UP, RULE_GAP_DN:
                return 32'(int'($urandom_range(0, 600)) - 300);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_bar(make_bar(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1));
        send_bar(make_bar('1, '1, '1, '1, '1, 1'b0));
        send_bar(make_bar(32'd5, 32'd9, 32'd1, 32'd7, 32'd100, 1'b0));
        end_items();
        wait_drained();
        // Indexes past the last register must change nothing.
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        send_bar(make_bar(32'd5, 32'd9, 32'd1, 32'd7, 32'd100, 1'b0));
        end_items();
    endtask

    task automatic test_directed_rules();
        setup_rule(RULE_INSIDE, 1'b0, 7'd1, 7'd1, 7'd1, 32'd0);
        send_bar(make_bar(32'd100, 32'd200, 32'd50, 32'd150, 32'd10, 1'b1));
        send_bar(make_bar(32'd120, 32'd200, 32'd50, 32'd130, 32'd10, 1'b0));
        send_bar(make_bar(32'd120, 32'd201, 32'd50, 32'd130, 32'd10, 1'b0));
        end_items();
        setup_rule(RULE_GAP_UP, 1'b0, 7'd1, 7'd1, 7'd1, 32'd0);
        send_bar(make_bar(32'd90, 32'd100, 32'd80, 32'd95, 32'd10, 1'b1));
        send_bar(make_bar(32'd101, 32'd110, 32'd100, 32'd105, 32'd10, 1'b0));
        send_bar(make_bar(32'd5, 32'd0, 32'd0, 32'd0, 32'd10, 1'b0));
        send_bar(make_bar(32'd5, 32'd6, 32'd1, 32'd2, 32'd10, 1'b0));
        end_items();
        // Change from a zero previous close gives no flag.
        setup_rule(RULE_CHG_UP, 1'b0, 7'd1, 7'd1, 7'd1, 32'h8000_0000);
        send_bar(make_bar(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1));
        send_bar(make_bar(32'd1, 32'd2, 32'd0, 32'd1, 32'd0, 1'b0));
        send_bar(make_bar('1, '1, '1, '1, '1, 1'b0));
        end_items();
        // Full-range close against the largest positive threshold.
        setup_rule(RULE_ABOVE, 1'b0, 7'd1, 7'd1, 7'd1, 32'h7FFF_FFFF);
        send_bar(make_bar('1, '1, '1, '1, '1, 1'b1));
        send_bar(make_bar(32'h7FFF_FFFF, '1, 32'd0, 32'h7FFF_FFFF, 32'd0, 1'b0));
        end_items();
        setup_rule(RULE_BELOW, 1'b0, 7'd1, 7'd1, 7'd1, 32'd0);
        send_bar(make_bar(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1));
        end_items();
        // Volume rule with a negative multiplier, first over all-zero volume, then a nonzero one.
        setup_rule(RULE_VOL_HI, 1'b0, 7'd2, 7'd1, 7'd1, 32'hFFFF_FF00);
        send_bar(make_bar(32'd1, 32'd2, 32'd0, 32'd1, 32'd0, 1'b1));
        send_bar(make_bar(32'd1, 32'd2, 32'd0, 32'd1, 32'd0, 1'b0));
        send_bar(make_bar(32'd1, 32'd2, 32'd0, 32'd1, 32'd0, 1'b0));
        send_bar(make_bar(32'd1, 32'd2, 32'd0, 32'd1, 32'd7, 1'b0));
        end_items();
        setup_rule(RULE_GAP_DN, 1'b1, 7'd0, 7'd127, 7'd64, 32'h8000_0000);
        send_bar(make_bar(32'd9, 32'd10, 32'd4, 32'd6, 32'd1, 1'b1));
        send_bar(make_bar(32'd1, 32'd3, 32'd0, 32'd2, 32'd1, 1'b0));
        send_bar(make_bar('1, '1, '1, '1, '1, 1'b0));
        end_items();
    endtask

    task automatic test_rule_sweep();
        logic [6:0]  pa, pb, pc;
        logic [31:0] thr;
        int          n;
        for (int rr = 0; rr < 32; rr++) begin
            walk_px = $urandom_range(100, 200000);
            walk_bias = longint'($urandom_range(0, 80)) - 40;
            burst_mode = ($urandom_range(0, 3) == 0);
            pa = pick_period();
            pb = pick_period();
            pc = pick_period();
            thr = pick_threshold(5'(rr));
            setup_rule(5'(rr), 1'($urandom_range(0, 1)), pa, pb, pc, thr);
            n = (pa == 0 || pa > 8 || pb > 8 || pc > 8) ? 70 : 45;
            for (int i = 0; i < n; i++)
                send_bar(walk_bar(i == 0 || $urandom_range(0, 39) == 0));
            end_items();
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_long_periods();
        setup_rule(RULE_BULL, 1'b1, 7'd64, 7'd64, 7'd64, 32'h7FFF_FFFF);
        walk_bias = 30;
        for (int i = 0; i < 70; i++) send_bar(walk_bar(i == 0));
        end_items();
        // Same series switched to simple averages and slope with the longest lookback.
        setup_rule(RULE_SLOPE_UP, 1'b0, 7'd1, 7'd64, 7'd64, 32'h8000_0000);
        walk_bias = -10;
        for (int i = 0; i < 70; i++) send_bar(walk_bar(1'b0));
        end_items();
    endtask

    always @(negedge i_clk) begin
        if (burst_mode) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    m_tready <= 1'b0;
                    stall_left <= $urandom_range(0, 2);
                end
                4: begin
                    m_tready <= 1'b0;
                    stall_left <= $urandom_range(10, 60);
                end
                default: m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (hit_q.size() == 0) begin
                $display("%0t: result with no bar pending, actual signal_hit %0b",
                         $time, m_tdata[0]);
                errors++;
            end else if (m_tdata[0] !== hit_q[0]) begin
                $display("%0t: signal_hit mismatch, expected %0b actual %0b",
                         $time, hit_q[0], m_tdata[0]);
                errors++;
                void'(hit_q.pop_front());
            end else begin
                void'(hit_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCH_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        rule_sel = RULE_ALWAYS;
        ema_sel = 1'b0;
        per_raw[0] = 7'd20;
        per_raw[1] = 7'd20;
        per_raw[2] = 7'd60;
        thr_val = 0;
        clear_series();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_rules();
        test_rule_sweep();
        test_long_periods();

        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (hit_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, hit_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/bcs_pkg.sv
hdl/bcs_cell.sv
hdl/bcs_ema.sv
hdl/bcs_judge.sv
hdl/bar_condition_signal_top.sv
tb/tb.sv
